// ===== rtl/pbf_pkg.sv =====
// Shared types and constants for the packet block fragmenter.
// No dependencies; every other file uses this package.
package pbf_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 16;
	localparam int BSIZE_W     = 7;
	localparam int MAX_BLOCK_D = 64;
	localparam int MIN_BLOCK   = 3;
	localparam int HDR_BYTES   = 2;
	localparam int DIV_CNT_W   = $clog2(LEN_W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_HDR_IDX,
		ST_HDR_CNT,
		ST_DATA,
		ST_PAD
	} pbf_state_t;

	typedef struct packed {
		logic               start;
		logic [LEN_W-1:0]   num;
		logic [BSIZE_W-1:0] den;
	} pbf_div_req_t;

	typedef struct packed {
		logic             done;
		logic [LEN_W-1:0] quot;
	} pbf_div_rsp_t;

endpackage

// ===== rtl/pbf_if.sv =====
// Handshake channels of the packet block fragmenter: input bytes,
// block stream out and block size writes. Depends on pbf_pkg.
interface pbf_in_if;
	logic                        valid;
	logic                        ready;
	logic [pbf_pkg::BYTE_W-1:0]  data_byte;
	logic [pbf_pkg::LEN_W-1:0]   packet_bytes;

	modport source (output valid, output data_byte, output packet_bytes, input ready);
	modport sink   (input valid, input data_byte, input packet_bytes, output ready);
endinterface

interface pbf_out_if;
	logic                        valid;
	logic                        ready;
	logic [pbf_pkg::BYTE_W-1:0]  out_byte;
	logic                        block_end;
	logic                        run_last;

	modport source (output valid, output out_byte, output block_end, output run_last,
		input ready);
	modport sink   (input valid, input out_byte, input block_end, input run_last,
		output ready);
endinterface

interface pbf_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [pbf_pkg::BSIZE_W-1:0] frag_size;

	modport source (output valid, output frag_size, input ready);
	modport sink   (input valid, input frag_size, output ready);
endinterface

// ===== rtl/packet_block_fragmenter_unit.sv =====
// Top level of the packet block fragmenter: sequencer, output register
// and block size register. Depends on pbf_pkg, pbf_if and pbf_div.
//
// Usage: payload bytes enter on pkt_in, each carrying the packet length.
// The block stream leaves on blk_out: for each byte, the two header bytes
// (block index, block count) when it opens a block, then the byte itself,
// then zero padding when it ends the packet. run_last marks the final
// result of an input transaction, block_end the final byte of a block.
// cfg writes frag_size (saturated to 3..MAX_BLOCK); write only while idle.
// Sequencing: one input transaction at a time. A byte in the middle of a
// block is accepted, then emitted; a block-opening byte adds the two header
// bytes; the first byte of a packet first waits for the block count from
// the divider, which produces one quotient bit per cycle; a packet-ending
// byte adds its padding bytes after it, up to the end of the block.
// A stalled receiver holds the output register; the sequencer waits and
// pkt_in stays not ready until the transaction's results are all loaded.
// Reset sets frag_size to 64 and clears all packet counters.
module packet_block_fragmenter_unit #(
	parameter int MAX_BLOCK = pbf_pkg::MAX_BLOCK_D
) (
	input  logic      clk,
	input  logic      arst_n,
	pbf_cfg_if.sink   cfg,
	pbf_in_if.sink    pkt_in,
	pbf_out_if.source blk_out
);
	import pbf_pkg::*;

	localparam int FILL_W = $clog2(MAX_BLOCK);

	pbf_state_t state_q, state_d;

	logic [BSIZE_W-1:0] frag_size_q;
	logic [BSIZE_W-1:0] bs_eff;
	logic [BSIZE_W-1:0] bs_q;
	logic [BYTE_W-1:0]  data_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   len_eff;
	logic [LEN_W-1:0]   bytes_taken_q;
	logic [BYTE_W-1:0]  block_index_q;
	logic [BYTE_W-1:0]  block_count_q;
	logic [FILL_W-1:0]  fill_q;

	logic [FILL_W:0]    fill_n;
	logic [LEN_W-1:0]   taken_n;
	logic               blk_full;
	logic               pkt_end;
	logic               accept;
	logic               can_emit;

	logic               emit;
	logic [BYTE_W-1:0]  emit_byte;
	logic               emit_end;
	logic               emit_last;

	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_end_q;
	logic               out_last_q;

	pbf_div_req_t div_req;
	pbf_div_rsp_t div_rsp;

	// block size register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_size_q <= BSIZE_W'(64);
		end else if (cfg.valid) begin
			frag_size_q <= cfg.frag_size;
		end
	end

	always_comb begin
		if (frag_size_q < BSIZE_W'(MIN_BLOCK)) begin
			bs_eff = BSIZE_W'(MIN_BLOCK);
		end else if (frag_size_q > BSIZE_W'(MAX_BLOCK)) begin
			bs_eff = BSIZE_W'(MAX_BLOCK);
		end else begin
			bs_eff = frag_size_q;
		end
	end

	assign len_eff = (pkt_in.packet_bytes == '0) ? LEN_W'(1) : pkt_in.packet_bytes;

	assign pkt_in.ready = (state_q == ST_IDLE);
	assign accept       = pkt_in.valid && pkt_in.ready;
	assign can_emit     = !out_valid_q || blk_out.ready;

	// ceil(len / room) = (len - 1) / room + 1
	assign div_req.start = accept && (bytes_taken_q == '0);
	assign div_req.num   = len_eff - 1'b1;
	assign div_req.den   = bs_eff - BSIZE_W'(HDR_BYTES);

	pbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign fill_n   = {1'b0, fill_q} + 1'b1;
	assign taken_n  = bytes_taken_q + 1'b1;
	assign blk_full = (BSIZE_W'(fill_n) >= bs_q);
	assign pkt_end  = (taken_n >= len_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (bytes_taken_q == '0) begin
						state_d = ST_DIV;
					end else if (fill_q == '0) begin
						state_d = ST_HDR_IDX;
					end else begin
						state_d = ST_DATA;
					end
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_HDR_IDX;
				end
			end
			ST_HDR_IDX: begin
				if (can_emit) begin
					state_d = ST_HDR_CNT;
				end
			end
			ST_HDR_CNT: begin
				if (can_emit) begin
					state_d = ST_DATA;
				end
			end
			ST_DATA: begin
				if (can_emit) begin
					state_d = (pkt_end && !blk_full) ? ST_PAD : ST_IDLE;
				end
			end
			ST_PAD: begin
				if (can_emit && blk_full) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		emit_byte = '0;
		emit_end  = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			ST_HDR_IDX: begin
				emit      = can_emit;
				emit_byte = block_index_q;
			end
			ST_HDR_CNT: begin
				emit      = can_emit;
				emit_byte = block_count_q;
			end
			ST_DATA: begin
				emit      = can_emit;
				emit_byte = data_q;
				emit_end  = blk_full;
				emit_last = !pkt_end || blk_full;
			end
			ST_PAD: begin
				emit      = can_emit;
				emit_end  = blk_full;
				emit_last = blk_full;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			bytes_taken_q <= '0;
			block_index_q <= '0;
			block_count_q <= '0;
			fill_q        <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_DIV: begin
					if (div_rsp.done) begin
						block_count_q <= div_rsp.quot[BYTE_W-1:0] + 1'b1;
						block_index_q <= '0;
						fill_q        <= '0;
					end
				end
				ST_HDR_CNT: begin
					if (can_emit) begin
						fill_q <= FILL_W'(HDR_BYTES);
					end
				end
				ST_DATA: begin
					if (can_emit) begin
						if (pkt_end) begin
							bytes_taken_q <= '0;
							block_index_q <= '0;
							block_count_q <= '0;
							fill_q        <= blk_full ? '0 : fill_n[FILL_W-1:0];
						end else begin
							bytes_taken_q <= taken_n;
							if (blk_full) begin
								fill_q        <= '0;
								block_index_q <= block_index_q + 1'b1;
							end else begin
								fill_q <= fill_n[FILL_W-1:0];
							end
						end
					end
				end
				ST_PAD: begin
					if (can_emit) begin
						fill_q <= blk_full ? '0 : fill_n[FILL_W-1:0];
					end
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

	// hold the transaction fields for the whole sequence
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= pkt_in.data_byte;
			len_q  <= len_eff;
			bs_q   <= bs_eff;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (blk_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_end_q  <= emit_end;
			out_last_q <= emit_last;
		end
	end

	assign blk_out.valid     = out_valid_q;
	assign blk_out.out_byte  = out_byte_q;
	assign blk_out.block_end = out_end_q;
	assign blk_out.run_last  = out_last_q;

endmodule

// ===== rtl/pbf_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pbf_pkg for widths and the request/response structs.
module pbf_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pbf_pkg::pbf_div_req_t req,
	output pbf_pkg::pbf_div_rsp_t rsp
);
	import pbf_pkg::*;

	logic [LEN_W-1:0]     num_q;
	logic [BSIZE_W-1:0]   den_q;
	logic [BSIZE_W-1:0]   rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [BSIZE_W:0]     trial;
	logic                 fits;

	assign trial = {rem_q, num_q[LEN_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (req.start) begin
				cnt_q  <= DIV_CNT_W'(LEN_W);
				done_q <= 1'b0;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == DIV_CNT_W'(1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// quotient bits shift in where numerator bits leave
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[LEN_W-2:0], fits};
			rem_q <= fits ? BSIZE_W'(trial - {1'b0, den_q}) : trial[BSIZE_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule
